/* rtl/nrmc_pkg.sv */
// Shared constants, types and helper functions for the RMC sentence parser.
package nrmc_pkg;

    localparam int MAX_SENTENCE_BYTES = 80;
    localparam int MAX_FIELD_CHARS    = 12;
    localparam int POS_W              = 4;
    localparam int COUNT_W            = 7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_LAST   = 4'd15;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_GGA   = 2'd2;

    typedef logic [MAX_FIELD_CHARS-1:0][7:0] fchars_t;

    typedef struct packed {
        logic        time_ok;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        lat_ok;
        logic [25:0] lat_mag;
        logic        lon_ok;
        logic [26:0] lon_mag;
    } field_dec_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Returns bit 4 set for a character that is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = 5'({1'b0, c[3:0]} + 5'd9);
        end
        return v;
    endfunction

endpackage

/* rtl/nmea_rmc_sentence_parser.sv */
// Top level of the NMEA RMC sentence parser: input register, byte logic, result register.
//
//  channel | handshake           | payload
//  input   | in_valid, in_stall  | data_byte, line_overrun
//  output  | out_valid, out_stall| sentence_kind .. fix_valid
//
// A sentence's last item passes the input register, then its result is registered.
// One item enters per cycle unless in_stall; the byte logic sets that rate.
// Reset clears the sentence state and loads the held time 23:59:55.
// A stalled output holds back only an item that ends a sentence.
module nmea_rmc_sentence_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               line_overrun,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         sentence_kind,
    output logic               checksum_ok,
    output logic [6:0]         hour,
    output logic [6:0]         minute,
    output logic [6:0]         second,
    output logic signed [26:0] latitude,
    output logic signed [27:0] longitude,
    output logic               fix_valid
);

    localparam int PW = nrmc_pkg::POS_W;
    localparam int CW = nrmc_pkg::COUNT_W;

    logic in_v_reg, in_v_next;
    logic [7:0] c_reg;
    logic ovr_reg;

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [7:0] xor_reg, xor_next;
    logic [3:0] fidx_reg, fidx_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0] star_reg, star_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] rcs_reg, rcs_next;
    logic hex_bad_reg, hex_bad_next;
    nrmc_pkg::fchars_t fch_reg, fch_next;

    logic t_pres_reg, t_pres_next;
    logic [6:0] t_h_reg, t_h_next, t_m_reg, t_m_next, t_s_reg, t_s_next;
    logic la_pres_reg, la_pres_next, la_s_reg, la_s_next;
    logic [25:0] la_mag_reg, la_mag_next;
    logic lo_pres_reg, lo_pres_next, lo_w_reg, lo_w_next;
    logic [26:0] lo_mag_reg, lo_mag_next;
    logic st_pres_reg, st_pres_next, st_fix_reg, st_fix_next;

    logic [6:0] hh_reg, hh_next, hm_reg, hm_next, hs_reg, hs_next;
    logic [26:0] hlat_reg, hlat_next;
    logic [27:0] hlon_reg, hlon_next;
    logic hfix_reg, hfix_next;

    logic out_v_reg, out_v_next;
    logic [1:0] o_kind_reg, o_kind_next;
    logic o_ok_reg, o_ok_next;

    nrmc_pkg::field_dec_t dec;
    logic produce, advance, fire;

    nrmc_field_dec u_dec (
        .chars (fch_reg),
        .len   (pos_reg),
        .dec   (dec)
    );

    assign produce  = (byte_count_reg != '0) && (star_reg == 2'd2);
    assign advance  = !(produce && out_v_reg && out_stall);
    assign fire     = in_v_reg && advance;
    assign in_stall = in_v_reg && !advance;

    always_comb
    begin
        logic [4:0] h;
        logic [CW-1:0] idx;
        logic [7:0] rmc_c, gga_c;
        logic closing, ok;
        logic [1:0] kind;

        in_v_next       = in_valid && !in_stall ? 1'b1 : (advance ? 1'b0 : in_v_reg);
        byte_count_next = byte_count_reg;
        xor_next        = xor_reg;
        fidx_next       = fidx_reg;
        pos_next        = pos_reg;
        star_next       = star_reg;
        kind_next       = kind_reg;
        rcs_next        = rcs_reg;
        hex_bad_next    = hex_bad_reg;
        fch_next        = fch_reg;
        t_pres_next = t_pres_reg; t_h_next = t_h_reg; t_m_next = t_m_reg; t_s_next = t_s_reg;
        la_pres_next = la_pres_reg; la_s_next = la_s_reg; la_mag_next = la_mag_reg;
        lo_pres_next = lo_pres_reg; lo_w_next = lo_w_reg; lo_mag_next = lo_mag_reg;
        st_pres_next = st_pres_reg; st_fix_next = st_fix_reg;
        hh_next = hh_reg; hm_next = hm_reg; hs_next = hs_reg;
        hlat_next = hlat_reg; hlon_next = hlon_reg; hfix_next = hfix_reg;
        o_kind_next = o_kind_reg;
        o_ok_next   = o_ok_reg;
        out_v_next  = (out_v_reg && !out_stall) ? 1'b0 : out_v_reg;
        h       = nrmc_pkg::hex_val(c_reg);
        idx     = byte_count_reg;
        rmc_c   = 8'h00;
        gga_c   = 8'h00;
        closing = 1'b0;
        ok      = 1'b0;
        kind    = nrmc_pkg::KIND_OTHER;

        if (fire)
        begin
            if (byte_count_reg == '0)
            begin
                if (c_reg == nrmc_pkg::CH_DOLLAR)
                begin
                    byte_count_next = CW'(1);
                    xor_next = '0; fidx_next = '0; pos_next = '0; star_next = '0;
                    kind_next = 2'b11; rcs_next = '0; hex_bad_next = 1'b0;
                    t_pres_next = 1'b0; la_pres_next = 1'b0; lo_pres_next = 1'b0;
                    st_pres_next = 1'b0; la_s_next = 1'b0; lo_w_next = 1'b0;
                    st_fix_next = 1'b0; t_h_next = '0; t_m_next = '0; t_s_next = '0;
                    la_mag_next = '0; lo_mag_next = '0;
                end
            end
            else
            begin
                byte_count_next = CW'(byte_count_reg + CW'(1));
                case (idx)
                    CW'(3): begin rmc_c = 8'h52; gga_c = 8'h47; end
                    CW'(4): begin rmc_c = 8'h4D; gga_c = 8'h47; end
                    CW'(5): begin rmc_c = 8'h43; gga_c = 8'h41; end
                    default: begin rmc_c = 8'h00; gga_c = 8'h00; end
                endcase
                if (idx >= CW'(3) && idx <= CW'(5))
                begin
                    if (c_reg != rmc_c) kind_next[0] = 1'b0;
                    if (c_reg != gga_c) kind_next[1] = 1'b0;
                end
                if (star_reg == 2'd0)
                begin
                    if (c_reg == nrmc_pkg::CH_STAR)
                    begin
                        closing   = 1'b1;
                        star_next = 2'd1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ c_reg;
                        if (c_reg == nrmc_pkg::CH_COMMA)
                        begin
                            closing = 1'b1;
                            if (fidx_reg < nrmc_pkg::FLD_LAST)
                            begin
                                fidx_next = 4'(fidx_reg + 4'd1);
                            end
                            pos_next = '0;
                        end
                        else if (fidx_reg != 4'd0
                                 && pos_reg < PW'(nrmc_pkg::MAX_FIELD_CHARS))
                        begin
                            for (int i = 0; i < nrmc_pkg::MAX_FIELD_CHARS; i++)
                            begin
                                if (pos_reg == PW'(i)) fch_next[i] = c_reg;
                            end
                            pos_next = PW'(pos_reg + PW'(1));
                        end
                    end
                    if (closing)
                    begin
                        case (fidx_reg)
                            nrmc_pkg::FLD_TIME:
                            begin
                                if (dec.time_ok)
                                begin
                                    t_pres_next = 1'b1; t_h_next = dec.hour;
                                    t_m_next = dec.minute; t_s_next = dec.second;
                                end
                            end
                            nrmc_pkg::FLD_STATUS:
                            begin
                                if (pos_reg != '0)
                                begin
                                    st_pres_next = 1'b1;
                                    st_fix_next  = (fch_reg[0] == nrmc_pkg::CH_A);
                                end
                            end
                            nrmc_pkg::FLD_LAT:
                            begin
                                if (dec.lat_ok)
                                begin
                                    la_pres_next = 1'b1; la_mag_next = dec.lat_mag;
                                end
                            end
                            nrmc_pkg::FLD_NS:
                            begin
                                if (pos_reg != '0) la_s_next = (fch_reg[0] == nrmc_pkg::CH_S);
                            end
                            nrmc_pkg::FLD_LON:
                            begin
                                if (dec.lon_ok)
                                begin
                                    lo_pres_next = 1'b1; lo_mag_next = dec.lon_mag;
                                end
                            end
                            nrmc_pkg::FLD_EW:
                            begin
                                if (pos_reg != '0) lo_w_next = (fch_reg[0] == nrmc_pkg::CH_W);
                            end
                            default: ;
                        endcase
                    end
                end
                else if (star_reg == 2'd1)
                begin
                    hex_bad_next = hex_bad_reg | h[4];
                    rcs_next     = {(h[4] ? 4'd0 : h[3:0]), 4'd0};
                    star_next    = 2'd2;
                end
                else
                begin
                    ok = !(hex_bad_reg | h[4])
                        && ({rcs_reg[7:4], (h[4] ? 4'd0 : h[3:0])} == xor_reg);
                    rcs_next = {rcs_reg[7:4], (h[4] ? 4'd0 : h[3:0])};
                    hex_bad_next = hex_bad_reg | h[4];
                    kind = kind_reg[0] ? nrmc_pkg::KIND_RMC
                         : (kind_reg[1] ? nrmc_pkg::KIND_GGA : nrmc_pkg::KIND_OTHER);
                    if (ok && kind == nrmc_pkg::KIND_RMC)
                    begin
                        if (t_pres_reg)
                        begin
                            hh_next = t_h_reg; hm_next = t_m_reg; hs_next = t_s_reg;
                        end
                        if (la_pres_reg)
                        begin
                            hlat_next = la_s_reg ? 27'(27'd0 - 27'(la_mag_reg)) : 27'(la_mag_reg);
                        end
                        if (lo_pres_reg)
                        begin
                            hlon_next = lo_w_reg ? 28'(28'd0 - 28'(lo_mag_reg)) : 28'(lo_mag_reg);
                        end
                        if (st_pres_reg) hfix_next = st_fix_reg;
                    end
                    o_kind_next     = kind;
                    o_ok_next       = ok;
                    out_v_next      = 1'b1;
                    byte_count_next = '0;
                    star_next       = 2'd0;
                end
                if (byte_count_next > CW'(nrmc_pkg::MAX_SENTENCE_BYTES - 1))
                begin
                    byte_count_next = '0;
                end
            end
            if (ovr_reg) byte_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg       <= 1'b0;
            byte_count_reg <= '0;
            xor_reg        <= '0;
            fidx_reg       <= '0;
            pos_reg        <= '0;
            star_reg       <= '0;
            kind_reg       <= '0;
            rcs_reg        <= '0;
            hex_bad_reg    <= 1'b0;
            t_pres_reg     <= 1'b0;
            la_pres_reg    <= 1'b0;
            lo_pres_reg    <= 1'b0;
            st_pres_reg    <= 1'b0;
            la_s_reg       <= 1'b0;
            lo_w_reg       <= 1'b0;
            st_fix_reg     <= 1'b0;
            t_h_reg        <= '0;
            t_m_reg        <= '0;
            t_s_reg        <= '0;
            la_mag_reg     <= '0;
            lo_mag_reg     <= '0;
            hh_reg         <= 7'd23;
            hm_reg         <= 7'd59;
            hs_reg         <= 7'd55;
            hlat_reg       <= '0;
            hlon_reg       <= '0;
            hfix_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            in_v_reg       <= in_v_next;
            byte_count_reg <= byte_count_next;
            xor_reg        <= xor_next;
            fidx_reg       <= fidx_next;
            pos_reg        <= pos_next;
            star_reg       <= star_next;
            kind_reg       <= kind_next;
            rcs_reg        <= rcs_next;
            hex_bad_reg    <= hex_bad_next;
            t_pres_reg     <= t_pres_next;
            la_pres_reg    <= la_pres_next;
            lo_pres_reg    <= lo_pres_next;
            st_pres_reg    <= st_pres_next;
            la_s_reg       <= la_s_next;
            lo_w_reg       <= lo_w_next;
            st_fix_reg     <= st_fix_next;
            t_h_reg        <= t_h_next;
            t_m_reg        <= t_m_next;
            t_s_reg        <= t_s_next;
            la_mag_reg     <= la_mag_next;
            lo_mag_reg     <= lo_mag_next;
            hh_reg         <= hh_next;
            hm_reg         <= hm_next;
            hs_reg         <= hs_next;
            hlat_reg       <= hlat_next;
            hlon_reg       <= hlon_next;
            hfix_reg       <= hfix_next;
            out_v_reg      <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            c_reg   <= data_byte;
            ovr_reg <= line_overrun;
        end
        fch_reg    <= fch_next;
        o_kind_reg <= o_kind_next;
        o_ok_reg   <= o_ok_next;
    end

    assign out_valid     = out_v_reg;
    assign sentence_kind = o_kind_reg;
    assign checksum_ok   = o_ok_reg;
    assign hour          = hh_reg;
    assign minute        = hm_reg;
    assign second        = hs_reg;
    assign latitude      = hlat_reg;
    assign longitude     = hlon_reg;
    assign fix_valid     = hfix_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> o_kind_reg != 2'd3)
        else $error("Result carries an undefined sentence kind.");

    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < CW'(nrmc_pkg::MAX_SENTENCE_BYTES))
        else $error("Byte count passed the sentence limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(nrmc_pkg::MAX_FIELD_CHARS))
        else $error("Field character position passed the buffer size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_v_reg && produce)
        else $error("Input stalled without a waiting result.");

endmodule

/* rtl/nrmc_field_dec.sv */
// Decoder for the time, latitude and longitude fields held in the field buffer.
module nrmc_field_dec (
    input  nrmc_pkg::fchars_t                chars,
    input  logic [nrmc_pkg::POS_W-1:0]       len,
    output nrmc_pkg::field_dec_t             dec
);

    logic [11:0] dig;
    logic [11:0][3:0] dv;

    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            if (i < nrmc_pkg::MAX_FIELD_CHARS)
            begin
                dig[i] = nrmc_pkg::is_digit(chars[i]);
                dv[i]  = chars[i][3:0];
            end
            else
            begin
                dig[i] = 1'b0;
                dv[i]  = 4'd0;
            end
        end
    end

    function automatic logic [6:0] two(input logic [3:0] hi, input logic [3:0] lo);
        return 7'(7'(hi) * 7'd10 + 7'(lo));
    endfunction

    logic [7:0] lon_deg;

    always_comb
    begin
        dec.time_ok = (len >= 4'd6) && (&dig[5:0]);
        dec.hour    = two(dv[0], dv[1]);
        dec.minute  = two(dv[2], dv[3]);
        dec.second  = two(dv[4], dv[5]);
        dec.lat_ok  = (len >= 4'd9) && (&dig[3:0]) && (&dig[8:5]);
        dec.lat_mag = 26'(26'(two(dv[0], dv[1])) * 26'd600000
                    + 26'(two(dv[2], dv[3])) * 26'd10000
                    + 26'(two(dv[5], dv[6])) * 26'd100
                    + 26'(two(dv[7], dv[8])));
        lon_deg     = 8'(8'(two(dv[1], dv[2]))
                    + ((chars[0] != nrmc_pkg::CH_ZERO) ? 8'd100 : 8'd0));
        dec.lon_ok  = (len >= 4'd10) && (&dig[4:0]) && (&dig[9:6]);
        dec.lon_mag = 27'(27'(lon_deg) * 27'd600000
                    + 27'(two(dv[3], dv[4])) * 27'd10000
                    + 27'(two(dv[6], dv[7])) * 27'd100
                    + 27'(two(dv[8], dv[9])));
    end

endmodule
